// ===== rtl/core/m8esc_pkg.sv =====
// Shared types and constants for the MARC-8 escape designation parser.
// No dependencies; used by the parser core, the top level and the checker.
package m8esc_pkg;

    // Character set identifiers
    localparam logic [3:0] SET_LATIN        = 4'd0;
    localparam logic [3:0] SET_ANSEL        = 4'd1;
    localparam logic [3:0] SET_GREEK_SYM    = 4'd2;
    localparam logic [3:0] SET_SUB          = 4'd3;
    localparam logic [3:0] SET_SUPER        = 4'd4;
    localparam logic [3:0] SET_ARABIC       = 4'd5;
    localparam logic [3:0] SET_ARABIC_EXT   = 4'd6;
    localparam logic [3:0] SET_HEBREW       = 4'd7;
    localparam logic [3:0] SET_CYRILLIC     = 4'd8;
    localparam logic [3:0] SET_CYRILLIC_EXT = 4'd9;
    localparam logic [3:0] SET_GREEK        = 4'd10;
    localparam logic [3:0] SET_EACC         = 4'd11;

    // Result status codes
    localparam logic [2:0] ST_DATA    = 3'd0;
    localparam logic [2:0] ST_ESC     = 3'd1;
    localparam logic [2:0] ST_APPLIED = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;
    localparam logic [2:0] ST_END     = 3'd5;

    // Escape and shortcut bytes
    localparam logic [7:0] C_ESC       = 8'h1B;
    localparam logic [7:0] C_SC_GREEK  = 8'h67;
    localparam logic [7:0] C_SC_SUB    = 8'h62;
    localparam logic [7:0] C_SC_SUPER  = 8'h70;
    localparam logic [7:0] C_SC_LATIN  = 8'h73;

    // Intermediate bytes
    localparam logic [7:0] C_DOLLAR    = 8'h24;
    localparam logic [7:0] C_G0_A      = 8'h28;
    localparam logic [7:0] C_G0_B      = 8'h2C;
    localparam logic [7:0] C_G1_A      = 8'h29;
    localparam logic [7:0] C_G1_B      = 8'h2D;
    localparam logic [7:0] C_BANG      = 8'h21;

    // Final bytes
    localparam logic [7:0] C_F_ARABIC     = 8'h33;
    localparam logic [7:0] C_F_ARABIC_EXT = 8'h34;
    localparam logic [7:0] C_F_LATIN      = 8'h42;
    localparam logic [7:0] C_F_CYRILLIC   = 8'h4E;
    localparam logic [7:0] C_F_CYR_EXT    = 8'h51;
    localparam logic [7:0] C_F_GREEK      = 8'h53;
    localparam logic [7:0] C_F_HEBREW     = 8'h32;
    localparam logic [7:0] C_F_ANSEL      = 8'h45;
    localparam logic [7:0] C_F_EACC       = 8'h31;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ESC   = 2'd1,
        PH_INTER = 2'd2
    } t_phase;

    typedef struct packed {
        logic multibyte;
        logic ansel_mark;
        logic g0_page;
        logic g1_page;
    } t_flags;

    typedef struct packed {
        logic       ok;
        logic [3:0] set;
    } t_sel;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] passed_byte;
        logic [3:0] g0_set;
        logic [3:0] g1_set;
    } t_result;

    // Set selected by a final byte, qualified by the intermediates seen.
    function automatic t_sel final_set(input logic [7:0] b, input t_flags f);
        t_sel s;
        logic plain;
        plain = !f.ansel_mark && !f.multibyte;
        s.ok  = 1'b0;
        s.set = SET_LATIN;
        unique case (b)
            C_F_ARABIC:     begin s.ok = plain; s.set = SET_ARABIC;       end
            C_F_ARABIC_EXT: begin s.ok = plain; s.set = SET_ARABIC_EXT;   end
            C_F_LATIN:      begin s.ok = plain; s.set = SET_LATIN;        end
            C_F_CYRILLIC:   begin s.ok = plain; s.set = SET_CYRILLIC;     end
            C_F_CYR_EXT:    begin s.ok = plain; s.set = SET_CYRILLIC_EXT; end
            C_F_GREEK:      begin s.ok = plain; s.set = SET_GREEK;        end
            C_F_HEBREW:     begin s.ok = plain; s.set = SET_HEBREW;       end
            C_F_ANSEL: begin
                s.ok  = f.ansel_mark && !f.multibyte;
                s.set = SET_ANSEL;
            end
            C_F_EACC: begin
                s.ok  = f.multibyte && !f.ansel_mark;
                s.set = SET_EACC;
            end
            default: s.ok = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/marc8_escape_designation_parser.sv =====
// Top level of the MARC-8 escape designation parser: input register,
// parser core and output register. Depends on m8esc_pkg and m8esc_parser.
//
// Usage:
//   Input channel: i_valid / o_stall carry one stream byte (i_code_byte) or
//   an end marker (i_stream_end) per beat. Output channel: o_valid / i_stall
//   carry one result per input beat: o_status, o_passed_byte and the G0/G1
//   designations after that byte.
//   Path: a beat taken into the input register is decoded by the parser core and
//   registered in the output register once the output side is free.
//   Throughput: one beat per cycle unless stalled; a byte's decode is a single pass
//   from the input register through the parser core into the output register.
//   Stall: while the output register holds an untaken result, the input
//   register still fills; o_stall rises only when both are full and i_stall
//   is high. Parser state advances only when a result enters the output
//   register, so nothing is lost or repeated.
//   Reset (synchronous, active low): both registers empty, G0 = basic latin,
//   G1 = ANSEL, parser idle with all sequence flags clear.
module marc8_escape_designation_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_code_byte,
    input  logic       i_stream_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_passed_byte,
    output logic [3:0] o_g0_set,
    output logic [3:0] o_g1_set
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_end;
    logic               r_out_valid;
    m8esc_pkg::t_result r_out;
    m8esc_pkg::t_result w_result;
    logic               w_adv;

    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_code_byte;
            r_in_end  <= i_stream_end;
        end
    end

    m8esc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_code_byte  (r_in_byte),
        .i_stream_end (r_in_end),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_passed_byte = r_out.passed_byte;
    assign o_g0_set      = r_out.g0_set;
    assign o_g1_set      = r_out.g1_set;

endmodule

// ===== rtl/core/m8esc_parser.sv =====
// Parser core: phase, sequence flags and G0/G1 designations, plus the
// single-pass decode of one byte. Depends on m8esc_pkg.
module m8esc_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_code_byte,
    input  logic                i_stream_end,
    output m8esc_pkg::t_result  o_result
);

    m8esc_pkg::t_phase r_phase, n_phase, w_phase;
    m8esc_pkg::t_flags r_flags, n_flags;
    logic [3:0]        r_g0, n_g0;
    logic [3:0]        r_g1, n_g1;

    logic              w_area;
    logic              w_inter_ok;
    m8esc_pkg::t_flags w_inter_flags;
    m8esc_pkg::t_sel   w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= m8esc_pkg::PH_IDLE;
            r_flags <= '0;
            r_g0    <= m8esc_pkg::SET_LATIN;
            r_g1    <= m8esc_pkg::SET_ANSEL;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_g0    <= n_g0;
            r_g1    <= n_g1;
        end
    end

    // Intermediate byte check against the flags collected so far
    always_comb begin
        w_area        = r_flags.multibyte || r_flags.g0_page || r_flags.g1_page;
        w_inter_ok    = 1'b1;
        w_inter_flags = r_flags;
        case (i_code_byte) inside
            m8esc_pkg::C_BANG: begin
                if (!w_area || r_flags.multibyte || r_flags.ansel_mark) begin
                    w_inter_ok = 1'b0;
                end else begin
                    w_inter_flags.ansel_mark = 1'b1;
                end
            end
            m8esc_pkg::C_DOLLAR: begin
                if (w_area) begin
                    w_inter_ok = 1'b0;
                end else begin
                    w_inter_flags.multibyte = 1'b1;
                end
            end
            m8esc_pkg::C_G0_A, m8esc_pkg::C_G0_B: begin
                if ((w_area && !r_flags.multibyte) || r_flags.g0_page || r_flags.g1_page) begin
                    w_inter_ok = 1'b0;
                end else begin
                    w_inter_flags.g0_page = 1'b1;
                end
            end
            m8esc_pkg::C_G1_A, m8esc_pkg::C_G1_B: begin
                if ((w_area && !r_flags.multibyte) || r_flags.g0_page || r_flags.g1_page) begin
                    w_inter_ok = 1'b0;
                end else begin
                    w_inter_flags.g1_page = 1'b1;
                end
            end
            default: w_inter_ok = 1'b0;
        endcase
        w_final = m8esc_pkg::final_set(i_code_byte, r_flags);
    end

    always_comb begin
        // the unused phase code behaves as idle
        w_phase = (r_phase == m8esc_pkg::PH_ESC || r_phase == m8esc_pkg::PH_INTER) ?
                  r_phase : m8esc_pkg::PH_IDLE;
        n_phase = w_phase;
        n_flags = r_flags;
        n_g0    = r_g0;
        n_g1    = r_g1;
        o_result.status      = m8esc_pkg::ST_ESC;
        o_result.passed_byte = 8'h00;

        if (i_stream_end) begin
            if (w_phase == m8esc_pkg::PH_IDLE) begin
                o_result.status = m8esc_pkg::ST_END;
            end else begin
                o_result.status = m8esc_pkg::ST_TRUNC;
                n_phase = m8esc_pkg::PH_IDLE;
                n_flags = '0;
            end
        end else begin
            unique case (w_phase)
                m8esc_pkg::PH_IDLE: begin
                    if (i_code_byte == m8esc_pkg::C_ESC) begin
                        n_phase         = m8esc_pkg::PH_ESC;
                        o_result.status = m8esc_pkg::ST_ESC;
                    end else begin
                        o_result.status      = m8esc_pkg::ST_DATA;
                        o_result.passed_byte = i_code_byte;
                    end
                end
                m8esc_pkg::PH_ESC: begin
                    n_phase         = m8esc_pkg::PH_IDLE;
                    n_flags         = '0;
                    o_result.status = m8esc_pkg::ST_APPLIED;
                    case (i_code_byte) inside
                        m8esc_pkg::C_SC_GREEK: n_g0 = m8esc_pkg::SET_GREEK_SYM;
                        m8esc_pkg::C_SC_SUB:   n_g0 = m8esc_pkg::SET_SUB;
                        m8esc_pkg::C_SC_SUPER: n_g0 = m8esc_pkg::SET_SUPER;
                        m8esc_pkg::C_SC_LATIN: n_g0 = m8esc_pkg::SET_LATIN;
                        m8esc_pkg::C_DOLLAR, m8esc_pkg::C_G0_A, m8esc_pkg::C_G0_B,
                        m8esc_pkg::C_G1_A, m8esc_pkg::C_G1_B: begin
                            // flags are clear here, so the first intermediate always passes
                            n_phase         = m8esc_pkg::PH_INTER;
                            n_flags         = w_inter_flags;
                            o_result.status = m8esc_pkg::ST_ESC;
                        end
                        default: o_result.status = m8esc_pkg::ST_INVALID;
                    endcase
                end
                m8esc_pkg::PH_INTER: begin
                    if (i_code_byte[7:4] == 4'h2) begin
                        if (w_inter_ok) begin
                            n_flags         = w_inter_flags;
                            o_result.status = m8esc_pkg::ST_ESC;
                        end else begin
                            n_phase         = m8esc_pkg::PH_IDLE;
                            n_flags         = '0;
                            o_result.status = m8esc_pkg::ST_INVALID;
                        end
                    end else begin
                        n_phase = m8esc_pkg::PH_IDLE;
                        n_flags = '0;
                        if (w_final.ok) begin
                            o_result.status = m8esc_pkg::ST_APPLIED;
                            if (r_flags.g1_page) begin
                                n_g1 = w_final.set;
                            end else begin
                                n_g0 = w_final.set;
                            end
                        end else begin
                            o_result.status = m8esc_pkg::ST_INVALID;
                        end
                    end
                end
                default: ;
            endcase
        end

        o_result.g0_set = n_g0;
        o_result.g1_set = n_g1;
    end

endmodule

// ===== rtl/core/m8esc_checker.sv =====
// Port-level checks for the MARC-8 escape designation parser, bound to the
// top level. Depends on m8esc_pkg.
module m8esc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_status,
    input logic [7:0] o_passed_byte,
    input logic [3:0] o_g0_set,
    input logic [3:0] o_g1_set
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_passed_byte)
                                  && $stable(o_g0_set) && $stable(o_g1_set)))
        else $error("result beat changed while stalled");

    // only plain data beats carry a byte
    a_passed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != m8esc_pkg::ST_DATA) |-> (o_passed_byte == 8'h00))
        else $error("passed byte set on a non-data beat");

    // designations move only on a beat that applies one
    a_desig_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) ##1 (o_valid && o_status != m8esc_pkg::ST_APPLIED)
        |-> ($stable(o_g0_set) && $stable(o_g1_set)))
        else $error("designation changed without an applied sequence");

    a_set_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_g0_set <= m8esc_pkg::SET_EACC && o_g1_set <= m8esc_pkg::SET_EACC
                     && o_status <= m8esc_pkg::ST_END))
        else $error("set or status code out of range");

endmodule

bind marc8_escape_designation_parser m8esc_checker u_m8esc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_passed_byte (o_passed_byte),
    .o_g0_set      (o_g0_set),
    .o_g1_set      (o_g1_set)
);
